FILE: sv/cras_pkg.sv
// ----------------------------------------------------------------------------
// cras_pkg
// Shared types and constants of the compressor restart and alert sequencer.
// ----------------------------------------------------------------------------
package cras_pkg;

    localparam int TIME_W   = 32;
    localparam int SETTLE_W = 16;
    localparam int ATT_W    = 4;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [TIME_W-1:0]   CALL_INTERVAL_RST  = 32'd900000;
    localparam logic [TIME_W-1:0]   ALERT_INTERVAL_RST = 32'd180000;
    localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST   = 16'd10000;
    localparam logic [ATT_W-1:0]    MAX_ATTEMPTS_RST   = 4'd3;

    typedef enum logic [1:0] {
        REG_CALL_INTERVAL  = 2'd0,
        REG_ALERT_INTERVAL = 2'd1,
        REG_SETTLE_TICKS   = 2'd2,
        REG_MAX_ATTEMPTS   = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_WAIT_OFF = 2'd1,
        PH_WAIT_ON  = 2'd2
    } phase_t;

endpackage

FILE: sv/compressor_restart_alert_sequencer.sv
// ----------------------------------------------------------------------------
// compressor_restart_alert_sequencer
// Restart and alert sequencer for a compressor, one sampled tick per
// transaction, with an APB register port for intervals and limits.
// ----------------------------------------------------------------------------
// Each accepted input transaction is one tick sample of run_sense and
// ready_sense; it produces exactly one result transaction, registered in the
// cycle after acceptance. A new sample is taken every cycle as long as the
// result register is empty or being drained in the same cycle, so the
// sustained rate is one transaction per cycle; the single result register
// sets that figure. The sequence state (tick count, call and alert times,
// failed attempts, phase, settle countdown, relay) advances once per accepted
// sample. Registers: call_interval at 0x0, alert_interval at 0x4,
// settle_ticks at 0x8 (0 acts as 1), max_attempts at 0xC; write them only
// while no transaction is in flight. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module compressor_restart_alert_sequencer
    import cras_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // APB configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // sample channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_run_sense,
    input  logic              s_ready_sense,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_relay_hold_off,
    output logic              m_call_request,
    output logic              m_still_off_text,
    output logic              m_restarted_text,
    output logic              m_sequence_busy
);

    logic [TIME_W-1:0]   call_interval_reg;
    logic [TIME_W-1:0]   alert_interval_reg;
    logic [SETTLE_W-1:0] settle_ticks_reg;
    logic [ATT_W-1:0]    max_attempts_reg;

    logic [TIME_W-1:0]   tick_count_reg,      tick_count_next;
    logic [TIME_W-1:0]   last_call_time_reg,  last_call_time_next;
    logic [TIME_W-1:0]   last_alert_time_reg, last_alert_time_next;
    logic [ATT_W-1:0]    failed_attempts_reg, failed_attempts_next;
    phase_t              phase_reg,           phase_next;
    logic [SETTLE_W-1:0] wait_left_reg,       wait_left_next;
    logic                relay_state_reg,     relay_state_next;

    logic m_valid_reg, m_valid_next;
    logic relay_out_reg, call_out_reg, text_out_reg, restart_out_reg, busy_out_reg;
    logic call_p, text_p, restart_p;

    logic                s_fire;
    logic                cfg_write;
    reg_idx_t            cfg_idx;
    logic [SETTLE_W-1:0] settle_load;
    logic                wait_expired;
    logic                call_due;
    logic                alert_due;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            call_interval_reg  <= CALL_INTERVAL_RST;
            alert_interval_reg <= ALERT_INTERVAL_RST;
            settle_ticks_reg   <= SETTLE_TICKS_RST;
            max_attempts_reg   <= MAX_ATTEMPTS_RST;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_CALL_INTERVAL:  call_interval_reg  <= pwdata;
                REG_ALERT_INTERVAL: alert_interval_reg <= pwdata;
                REG_SETTLE_TICKS:   settle_ticks_reg   <= pwdata[SETTLE_W-1:0];
                REG_MAX_ATTEMPTS:   max_attempts_reg   <= pwdata[ATT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_CALL_INTERVAL:  prdata = call_interval_reg;
            REG_ALERT_INTERVAL: prdata = alert_interval_reg;
            REG_SETTLE_TICKS:   prdata = {{(APB_DW-SETTLE_W){1'b0}}, settle_ticks_reg};
            REG_MAX_ATTEMPTS:   prdata = {{(APB_DW-ATT_W){1'b0}}, max_attempts_reg};
        endcase
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    assign settle_load  = (settle_ticks_reg == '0) ? SETTLE_W'(1) : settle_ticks_reg;
    assign wait_expired = (wait_left_reg <= SETTLE_W'(1));
    assign call_due     = ((tick_count_reg - last_call_time_reg) >= call_interval_reg);
    assign alert_due    = ((tick_count_reg - last_alert_time_reg) >= alert_interval_reg);

    // next state
    always_comb begin
        tick_count_next      = tick_count_reg + TIME_W'(1);
        last_call_time_next  = last_call_time_reg;
        last_alert_time_next = last_alert_time_reg;
        failed_attempts_next = failed_attempts_reg;
        phase_next           = phase_reg;
        wait_left_next       = wait_left_reg;
        relay_state_next     = relay_state_reg;
        unique case (phase_reg)
            PH_WAIT_OFF: begin
                if (wait_expired) begin
                    wait_left_next = '0;
                    if (s_ready_sense) begin
                        relay_state_next = 1'b0;
                        phase_next       = PH_WAIT_ON;
                        wait_left_next   = settle_load;
                    end else if (failed_attempts_reg < max_attempts_reg) begin
                        failed_attempts_next = failed_attempts_reg + ATT_W'(1);
                        phase_next           = PH_IDLE;
                    end else begin
                        relay_state_next     = 1'b0;
                        failed_attempts_next = '0;
                        phase_next           = PH_WAIT_ON;
                        wait_left_next       = settle_load;
                    end
                end else begin
                    wait_left_next = wait_left_reg - SETTLE_W'(1);
                end
            end
            PH_WAIT_ON: begin
                if (wait_expired) begin
                    wait_left_next = '0;
                    phase_next     = PH_IDLE;
                end else begin
                    wait_left_next = wait_left_reg - SETTLE_W'(1);
                end
            end
            default: begin
                phase_next = PH_IDLE;
                if (!s_run_sense) begin
                    if (call_due) begin
                        last_call_time_next = tick_count_reg;
                    end else if (alert_due) begin
                        last_alert_time_next = tick_count_reg;
                    end
                    relay_state_next = 1'b1;
                    phase_next       = PH_WAIT_OFF;
                    wait_left_next   = settle_load;
                end
            end
        endcase
    end

    // outputs
    always_comb begin
        call_p    = 1'b0;
        text_p    = 1'b0;
        restart_p = 1'b0;
        unique case (phase_reg)
            PH_WAIT_OFF: ;
            PH_WAIT_ON: begin
                restart_p = wait_expired && s_run_sense;
            end
            default: begin
                if (!s_run_sense) begin
                    call_p = call_due;
                    text_p = !call_due && alert_due;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg      <= '0;
            last_call_time_reg  <= '0;
            last_alert_time_reg <= '0;
            failed_attempts_reg <= '0;
            phase_reg           <= PH_IDLE;
            wait_left_reg       <= '0;
            relay_state_reg     <= 1'b0;
        end else if (s_fire) begin
            tick_count_reg      <= tick_count_next;
            last_call_time_reg  <= last_call_time_next;
            last_alert_time_reg <= last_alert_time_next;
            failed_attempts_reg <= failed_attempts_next;
            phase_reg           <= phase_next;
            wait_left_reg       <= wait_left_next;
            relay_state_reg     <= relay_state_next;
        end
    end

    assign m_valid_next = s_fire || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            relay_out_reg   <= relay_state_next;
            call_out_reg    <= call_p;
            text_out_reg    <= text_p;
            restart_out_reg <= restart_p;
            busy_out_reg    <= (phase_next != PH_IDLE);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_relay_hold_off = relay_out_reg;
    assign m_call_request   = call_out_reg;
    assign m_still_off_text = text_out_reg;
    assign m_restarted_text = restart_out_reg;
    assign m_sequence_busy  = busy_out_reg;

endmodule

FILE: sv/cras_checker.sv
// ----------------------------------------------------------------------------
// cras_checker
// Port-level checks of the sequencer's result transactions, bound to the top.
// ----------------------------------------------------------------------------
module cras_port_checks (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input logic m_relay_hold_off,
    input logic m_call_request,
    input logic m_still_off_text,
    input logic m_restarted_text,
    input logic m_sequence_busy
);

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_call_request, m_still_off_text, m_restarted_text}))
        else $error("more than one request pulse in a transaction");

    a_alert_holds_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_call_request || m_still_off_text) |->
            m_relay_hold_off && m_sequence_busy)
        else $error("alert without relay held off and sequence running");

    a_restart_released: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_restarted_text |-> !m_relay_hold_off && !m_sequence_busy)
        else $error("restarted text while relay held or sequence busy");

    a_result_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_relay_hold_off)
            && $stable(m_sequence_busy))
        else $error("stalled result transaction changed");

endmodule

bind compressor_restart_alert_sequencer cras_port_checks u_cras_port_checks (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_relay_hold_off (m_relay_hold_off),
    .m_call_request   (m_call_request),
    .m_still_off_text (m_still_off_text),
    .m_restarted_text (m_restarted_text),
    .m_sequence_busy  (m_sequence_busy)
);

FILE: tb/cras_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cras_checker
// Watches the register port and both transaction channels of the compressor
// restart and alert sequencer, predicts each result transaction from the
// accepted samples, and compares results and register reads field by field.
// ----------------------------------------------------------------------------
module cras_checker
    import cras_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic [APB_DW-1:0] prdata,
    input  logic              pready,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              s_run_sense,
    input  logic              s_ready_sense,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_relay_hold_off,
    input  logic              m_call_request,
    input  logic              m_still_off_text,
    input  logic              m_restarted_text,
    input  logic              m_sequence_busy,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        logic relay_hold_off;
        logic call_request;
        logic still_off_text;
        logic restarted_text;
        logic sequence_busy;
    } tick_outcome_t;

    logic [TIME_W-1:0]   cfg_call_iv;
    logic [TIME_W-1:0]   cfg_alert_iv;
    logic [SETTLE_W-1:0] cfg_settle;
    logic [ATT_W-1:0]    cfg_max_tries;

    logic [TIME_W-1:0]   tick_now;
    logic [TIME_W-1:0]   last_call_at;
    logic [TIME_W-1:0]   last_alert_at;
    logic [ATT_W-1:0]    failed_tries;
    phase_t              seq_phase;
    logic [SETTLE_W-1:0] settle_left;
    logic                relay_on;

    tick_outcome_t       tick_outcomes_q[$];
    tick_outcome_t       want;
    tick_outcome_t       got;
    int                  mismatches = 0;

    function automatic logic [SETTLE_W-1:0] settle_reload();
        return (cfg_settle == '0) ? SETTLE_W'(1) : cfg_settle;
    endfunction

    function automatic logic settle_expired();
        if (settle_left <= SETTLE_W'(1)) begin
            settle_left = '0;
            return 1'b1;
        end
        settle_left = settle_left - SETTLE_W'(1);
        return 1'b0;
    endfunction

    function automatic logic [APB_DW-1:0] reg_value(reg_idx_t r);
        case (r)
            REG_CALL_INTERVAL:  return APB_DW'(cfg_call_iv);
            REG_ALERT_INTERVAL: return APB_DW'(cfg_alert_iv);
            REG_SETTLE_TICKS:   return APB_DW'(cfg_settle);
            default:            return APB_DW'(cfg_max_tries);
        endcase
    endfunction

    task automatic step_sequence(input logic run, input logic rdy, output tick_outcome_t o);
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] since_call;
        logic [TIME_W-1:0] since_alert;
        now = tick_now;
        since_call = now - last_call_at;
        since_alert = now - last_alert_at;
        o = '0;
        case (seq_phase)
            PH_WAIT_OFF: begin
                if (settle_expired()) begin
                    if (rdy) begin
                        relay_on = 1'b0;
                        seq_phase = PH_WAIT_ON;
                        settle_left = settle_reload();
                    end else if (failed_tries < cfg_max_tries) begin
                        failed_tries = failed_tries + ATT_W'(1);
                        seq_phase = PH_IDLE;
                    end else begin
                        relay_on = 1'b0;
                        failed_tries = '0;
                        seq_phase = PH_WAIT_ON;
                        settle_left = settle_reload();
                    end
                end
            end
            PH_WAIT_ON: begin
                if (settle_expired()) begin
                    o.restarted_text = run;
                    seq_phase = PH_IDLE;
                end
            end
            default: begin
                seq_phase = PH_IDLE;
                if (!run) begin
                    if (since_call >= cfg_call_iv) begin
                        last_call_at = now;
                        o.call_request = 1'b1;
                    end else if (since_alert >= cfg_alert_iv) begin
                        last_alert_at = now;
                        o.still_off_text = 1'b1;
                    end
                    relay_on = 1'b1;
                    seq_phase = PH_WAIT_OFF;
                    settle_left = settle_reload();
                end
            end
        endcase
        tick_now = now + TIME_W'(1);
        o.relay_hold_off = relay_on;
        o.sequence_busy = (seq_phase != PH_IDLE);
    endtask

    task automatic report(input string what, input logic [APB_DW-1:0] exp_v,
                          input logic [APB_DW-1:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch %s: expected 0x%0h, got 0x%0h", $realtime, what, exp_v, act_v);
    endtask

    task automatic check_bit(input string what, input logic exp_b, input logic act_b);
        if (act_b !== exp_b)
            report(what, APB_DW'(exp_b), APB_DW'(act_b));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_call_iv   = CALL_INTERVAL_RST;
            cfg_alert_iv  = ALERT_INTERVAL_RST;
            cfg_settle    = SETTLE_TICKS_RST;
            cfg_max_tries = MAX_ATTEMPTS_RST;
            tick_now      = '0;
            last_call_at  = '0;
            last_alert_at = '0;
            failed_tries  = '0;
            seq_phase     = PH_IDLE;
            settle_left   = '0;
            relay_on      = 1'b0;
            tick_outcomes_q.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (reg_idx_t'(paddr[APB_AW-1:2]))
                        REG_CALL_INTERVAL:  cfg_call_iv = pwdata[TIME_W-1:0];
                        REG_ALERT_INTERVAL: cfg_alert_iv = pwdata[TIME_W-1:0];
                        REG_SETTLE_TICKS:   cfg_settle = pwdata[SETTLE_W-1:0];
                        REG_MAX_ATTEMPTS:   cfg_max_tries = pwdata[ATT_W-1:0];
                        default: ;
                    endcase
                end else if (prdata !== reg_value(reg_idx_t'(paddr[APB_AW-1:2]))) begin
                    report("register read", reg_value(reg_idx_t'(paddr[APB_AW-1:2])), prdata);
                end
            end
            if (s_valid && s_ready) begin
                step_sequence(s_run_sense, s_ready_sense, want);
                tick_outcomes_q.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = '{m_relay_hold_off, m_call_request, m_still_off_text,
                        m_restarted_text, m_sequence_busy};
                if (tick_outcomes_q.size() == 0) begin
                    report("unexpected result transaction", '0, APB_DW'(got));
                end else begin
                    want = tick_outcomes_q.pop_front();
                    check_bit("relay_hold_off", want.relay_hold_off, got.relay_hold_off);
                    check_bit("call_request", want.call_request, got.call_request);
                    check_bit("still_off_text", want.still_off_text, got.still_off_text);
                    check_bit("restarted_text", want.restarted_text, got.restarted_text);
                    check_bit("sequence_busy", want.sequence_busy, got.sequence_busy);
                end
            end
        end
        pending    <= tick_outcomes_q.size();
        fail_count <= mismatches;
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the compressor restart and alert sequencer: a
// directed opening, then random tick samples under several register settings
// (interval, settle and attempt extremes), with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
    import cras_pkg::*;

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_run_sense = 1'b0;
    logic              s_ready_sense = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_relay_hold_off;
    logic              m_call_request;
    logic              m_still_off_text;
    logic              m_restarted_text;
    logic              m_sequence_busy;

    int                fail_count;
    int                pending;
    bit                idle_on = 1'b0;
    int                stall_left = 0;

    compressor_restart_alert_sequencer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_run_sense      (s_run_sense),
        .s_ready_sense    (s_ready_sense),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_relay_hold_off (m_relay_hold_off),
        .m_call_request   (m_call_request),
        .m_still_off_text (m_still_off_text),
        .m_restarted_text (m_restarted_text),
        .m_sequence_busy  (m_sequence_busy)
    );

    cras_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_run_sense      (s_run_sense),
        .s_ready_sense    (s_ready_sense),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_relay_hold_off (m_relay_hold_off),
        .m_call_request   (m_call_request),
        .m_still_off_text (m_still_off_text),
        .m_restarted_text (m_restarted_text),
        .m_sequence_busy  (m_sequence_busy),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("FAIL compressor_restart_alert_sequencer");
        $finish;
    end

    // stall the result channel in bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic apb_access(input reg_idx_t r, input logic wr, input logic [APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= APB_AW'({r, 2'b00});
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_all_regs();
        for (int i = 0; i < 4; i++)
            apb_access(reg_idx_t'(i), 1'b0, '0);
    endtask

    task automatic set_config(input logic [APB_DW-1:0] call_iv, input logic [APB_DW-1:0] alert_iv,
                              input logic [APB_DW-1:0] settle, input logic [APB_DW-1:0] max_tries);
        apb_access(REG_CALL_INTERVAL, 1'b1, call_iv);
        apb_access(REG_ALERT_INTERVAL, 1'b1, alert_iv);
        apb_access(REG_SETTLE_TICKS, 1'b1, settle);
        apb_access(REG_MAX_ATTEMPTS, 1'b1, max_tries);
        read_all_regs();
    endtask

    task automatic send_sample(input logic run, input logic rdy);
        s_valid <= 1'b1;
        s_run_sense <= run;
        s_ready_sense <= rdy;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold off until every result has drained, then let the pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_random(input int n, input int run_pct, input int ready_pct, input bit calm);
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0)
                idle_on = calm ? 1'b0 : ($urandom_range(0, 2) != 0);
            if (idle_on && $urandom_range(0, 3) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            send_sample($urandom_range(0, 99) < run_pct, $urandom_range(0, 99) < ready_pct);
        end
        drain();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        read_all_regs();

        // text, not-ready retry, forced start, restart, ready on check; zero settle
        set_config(32'd2, 32'd0, 32'd0, 32'd1);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b0);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b0, 1'b1);
        send_sample(1'b0, 1'b1);
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b1);
        send_sample(1'b1, 1'b1);
        send_sample(1'b1, 1'b1);
        drain();

        set_config(32'd0, 32'd0, 32'd0, 32'd0);
        run_random(150, 30, 50, 1'b0);
        // upper bits beyond the register widths are dropped
        set_config(32'd40, 32'd7, 32'hABCD_0003, 32'h0000_F0F2);
        run_random(250, 30, 50, 1'b0);
        set_config(32'hFFFF_FFFF, 32'd15, 32'd2, 32'd15);
        run_random(250, 20, 8, 1'b0);
        set_config(32'd25, 32'hFFFF_FFFF, 32'd1, 32'd5);
        run_random(250, 35, 40, 1'b0);
        set_config(32'd100, 32'd20, 32'd65535, 32'd3);
        run_random(100, 25, 70, 1'b0);
        set_config(32'd60, 32'd9, 32'd4, 32'd1);
        run_random(340, 30, 50, 1'b1);

        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS compressor_restart_alert_sequencer");
        end else begin
            $display("FAIL compressor_restart_alert_sequencer");
        end
        $finish;
    end

endmodule
